>>> sv/tvpc_pkg.sv
package tvpc_pkg;

	localparam int CMD_W      = 2;
	localparam int PCT_W      = 7;
	localparam int MODE_W     = 2;
	localparam int PRESS_W    = 16;
	localparam int FST_W      = 16;
	localparam int RATIO_W    = 12;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// unit = full_scale_time / 100 is at most 655
	localparam int UNIT_W     = 10;
	localparam int SPAN_W     = UNIT_W + PCT_W;
	localparam int VPROD_W    = RATIO_W + SPAN_W;
	// scaled vent time stays below 2**20
	localparam int RUN_W      = 20;
	localparam int ELAPSED_W  = RUN_W + 1;
	localparam int SINCE_W    = 4;
	localparam int DROP_W     = 8;

	// reciprocal of 100 with 19 fraction bits, rounded up
	localparam int RECIP_SHIFT = 19;
	localparam int RECIP_100   = 5243;
	localparam int RECIP_W     = 13;
	localparam int QPROD_W     = FST_W + RECIP_W;

	localparam logic [CMD_W-1:0] CMD_TICK    = 2'd0;
	localparam logic [CMD_W-1:0] CMD_PERCENT = 2'd1;
	localparam logic [CMD_W-1:0] CMD_REARM   = 2'd2;

	localparam logic [MODE_W-1:0] MODE_CLOSED = 2'd0;
	localparam logic [MODE_W-1:0] MODE_FILL   = 2'd1;
	localparam logic [MODE_W-1:0] MODE_VENT   = 2'd2;
	localparam logic [MODE_W-1:0] MODE_EMERG  = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_FULL_SCALE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LIMIT      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_VENT_RATIO = 2'd2;

	localparam logic [FST_W-1:0]   FULL_SCALE_RESET = 16'd100;
	localparam logic [PRESS_W-1:0] LIMIT_RESET      = 16'd1000;
	localparam logic [RATIO_W-1:0] RATIO_RESET      = 12'd256;

	localparam int UPDATE_GAP    = 10;
	localparam int FILL_STEP     = 10;
	localparam int REARM_VENT_MS = 3000;
	localparam int FULL_PERCENT  = 100;

	typedef struct packed {
		logic [CMD_W-1:0] command;
		logic [PCT_W-1:0] target_percent;
	} in_item_t;

	typedef struct packed {
		logic               fill_valve;
		logic               vent_valve;
		logic [MODE_W-1:0]  valve_mode;
		logic [PRESS_W-1:0] pressure_estimate;
		logic [PCT_W-1:0]   current_percent;
		logic               emergency;
	} out_item_t;

	typedef struct packed {
		logic [FST_W-1:0]   full_scale_time;
		logic [PRESS_W-1:0] pressure_limit;
		logic [RATIO_W-1:0] vent_ratio;
	} cfg_t;

	typedef struct packed {
		logic accept;
		logic timer;
		logic press;
		logic unit0;
		logic unit1;
		logic unit2;
		logic unit3;
		logic apply;
		logic load;
	} ctrl_cmd_t;

	typedef struct packed {
		logic out_free;
	} ctrl_sts_t;

endpackage

>>> sv/tvpc_cfg.sv
module tvpc_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [tvpc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tvpc_pkg::CFG_DATA_W-1:0] cfg_data,
	output tvpc_pkg::cfg_t                 cfg
);
	import tvpc_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.full_scale_time <= FULL_SCALE_RESET;
			cfg_q.pressure_limit  <= LIMIT_RESET;
			cfg_q.vent_ratio      <= RATIO_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_FULL_SCALE: cfg_q.full_scale_time <= cfg_data[FST_W-1:0];
				REG_LIMIT:      cfg_q.pressure_limit  <= cfg_data[PRESS_W-1:0];
				REG_VENT_RATIO: cfg_q.vent_ratio      <= cfg_data[RATIO_W-1:0];
				default: begin
					// unmapped index: drop the write
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> sv/tvpc_ctrl.sv
module tvpc_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  logic [tvpc_pkg::CMD_W-1:0] in_command,
	output logic                      in_ready,
	input  tvpc_pkg::ctrl_sts_t       sts,
	output tvpc_pkg::ctrl_cmd_t       cmd
);
	import tvpc_pkg::*;

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_UNIT0 = 4'd1;
	localparam logic [3:0] ST_UNIT1 = 4'd2;
	localparam logic [3:0] ST_UNIT2 = 4'd3;
	localparam logic [3:0] ST_UNIT3 = 4'd4;
	localparam logic [3:0] ST_APPLY = 4'd5;
	localparam logic [3:0] ST_TIMER = 4'd6;
	localparam logic [3:0] ST_PRESS = 4'd7;
	localparam logic [3:0] ST_DONE  = 4'd8;

	logic [3:0] state_q;
	logic [3:0] state_nxt;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		state_nxt  = state_q;
		cmd        = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					unique case (in_command)
						CMD_TICK:    state_nxt = ST_TIMER;
						CMD_PERCENT: state_nxt = ST_UNIT0;
						CMD_REARM:   state_nxt = ST_APPLY;
						default:     state_nxt = ST_DONE;
					endcase
				end
			end
			ST_UNIT0: begin
				cmd.unit0 = 1'b1;
				state_nxt = ST_UNIT1;
			end
			ST_UNIT1: begin
				cmd.unit1 = 1'b1;
				state_nxt = ST_UNIT2;
			end
			ST_UNIT2: begin
				cmd.unit2 = 1'b1;
				state_nxt = ST_UNIT3;
			end
			ST_UNIT3: begin
				cmd.unit3 = 1'b1;
				state_nxt = ST_APPLY;
			end
			ST_APPLY: begin
				cmd.apply = 1'b1;
				state_nxt = ST_DONE;
			end
			ST_TIMER: begin
				cmd.timer = 1'b1;
				state_nxt = ST_PRESS;
			end
			ST_PRESS: begin
				cmd.press = 1'b1;
				state_nxt = ST_DONE;
			end
			ST_DONE: begin
				// hold until the result slot can take the item
				if (sts.out_free) begin
					cmd.load  = 1'b1;
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

>>> sv/tvpc_datapath.sv
module tvpc_datapath (
	input  logic                 clk,
	input  logic                 arst_n,
	input  tvpc_pkg::cfg_t       cfg,
	input  tvpc_pkg::in_item_t   in_item,
	input  tvpc_pkg::ctrl_cmd_t  cmd,
	output tvpc_pkg::ctrl_sts_t  sts,
	output logic                 out_valid,
	input  logic                 out_ready,
	output tvpc_pkg::out_item_t  out_item
);
	import tvpc_pkg::*;

	// controller state
	logic [MODE_W-1:0]    mode_q;
	logic                 timing_q;
	logic [ELAPSED_W-1:0] elapsed_q;
	logic [RUN_W-1:0]     run_q;
	logic [SINCE_W-1:0]   since_q;
	logic [PRESS_W-1:0]   pressure_q;
	logic [PCT_W-1:0]     percent_q;
	logic                 halted_q;
	logic                 out_valid_q;

	// working registers
	in_item_t             item_q;
	logic [UNIT_W-1:0]    q0_q;
	logic [SPAN_W-1:0]    chk_q;
	logic                 fill_q;
	logic [PCT_W-1:0]     change_q;
	logic [SPAN_W-1:0]    span_q;
	logic [RUN_W-1:0]     vspan_q;
	logic [DROP_W-1:0]    drop_q;
	out_item_t            out_q;

	logic [QPROD_W-1:0]   qprod;
	logic [UNIT_W-1:0]    unit;
	logic [VPROD_W-1:0]   vprod;
	logic [PRESS_W-1:0]   dprod;
	logic [PRESS_W:0]     fill_sum;
	logic                 upd;
	logic [PRESS_W-1:0]   press_nxt;
	logic                 pct_ok;

	assign qprod = QPROD_W'(cfg.full_scale_time) * QPROD_W'(RECIP_100);
	// the reciprocal runs high by at most one; step back if q0*100 overshoots
	assign unit  = (chk_q > SPAN_W'(cfg.full_scale_time)) ? q0_q - UNIT_W'(1) : q0_q;
	assign vprod = VPROD_W'(cfg.vent_ratio) * VPROD_W'(span_q);
	assign dprod = PRESS_W'(cfg.vent_ratio) * PRESS_W'(UPDATE_GAP);

	assign fill_sum = {1'b0, pressure_q} + (PRESS_W+1)'(FILL_STEP);
	assign upd = ((mode_q == MODE_FILL) || (mode_q == MODE_VENT)) &&
		(since_q > SINCE_W'(UPDATE_GAP));

	always_comb begin
		press_nxt = pressure_q;
		if (upd) begin
			if (mode_q == MODE_FILL) begin
				press_nxt = fill_sum[PRESS_W] ? '1 : fill_sum[PRESS_W-1:0];
			end else begin
				press_nxt = (PRESS_W'(drop_q) >= pressure_q) ? '0 :
					pressure_q - PRESS_W'(drop_q);
			end
		end
	end

	assign pct_ok = (mode_q != MODE_EMERG) && (item_q.target_percent <= PCT_W'(FULL_PERCENT));

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			item_q <= in_item;
		end
		if (cmd.unit0) begin
			q0_q     <= qprod[RECIP_SHIFT +: UNIT_W];
			fill_q   <= item_q.target_percent > percent_q;
			change_q <= (item_q.target_percent > percent_q) ?
				item_q.target_percent - percent_q : percent_q - item_q.target_percent;
		end
		if (cmd.unit1) begin
			chk_q <= SPAN_W'(q0_q) * SPAN_W'(FULL_PERCENT);
		end
		if (cmd.unit2) begin
			span_q <= SPAN_W'(unit) * SPAN_W'(change_q);
		end
		if (cmd.unit3) begin
			vspan_q <= vprod[8 +: RUN_W];
		end
		if (cmd.timer) begin
			drop_q <= dprod[8 +: DROP_W];
		end
		if (cmd.load) begin
			out_q.fill_valve        <= (mode_q == MODE_FILL);
			out_q.vent_valve        <= (mode_q != MODE_CLOSED);
			out_q.valve_mode        <= mode_q;
			out_q.pressure_estimate <= pressure_q;
			out_q.current_percent   <= percent_q;
			out_q.emergency         <= halted_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_CLOSED;
			timing_q    <= 1'b0;
			elapsed_q   <= '0;
			run_q       <= '0;
			since_q     <= '0;
			pressure_q  <= '0;
			percent_q   <= '0;
			halted_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.accept && (in_item.command == CMD_TICK)) begin
				if (elapsed_q != '1) begin
					elapsed_q <= elapsed_q + ELAPSED_W'(1);
				end
				if (since_q != '1) begin
					since_q <= since_q + SINCE_W'(1);
				end
			end
			if (cmd.timer && timing_q && (elapsed_q > ELAPSED_W'(run_q))) begin
				timing_q <= 1'b0;
				if (mode_q != MODE_EMERG) begin
					mode_q <= MODE_CLOSED;
				end
			end
			if (cmd.press) begin
				if (upd) begin
					since_q    <= '0;
					pressure_q <= press_nxt;
				end
				if (press_nxt > cfg.pressure_limit) begin
					mode_q   <= MODE_EMERG;
					halted_q <= 1'b1;
				end
			end
			if (cmd.apply) begin
				if (item_q.command == CMD_PERCENT) begin
					if (pct_ok) begin
						mode_q    <= fill_q ? MODE_FILL : MODE_VENT;
						timing_q  <= 1'b1;
						elapsed_q <= '0;
						run_q     <= fill_q ? RUN_W'(span_q) : vspan_q;
						percent_q <= item_q.target_percent;
					end
				end else if (mode_q == MODE_EMERG) begin
					// re-arm: release the stop and vent for a fixed time
					mode_q     <= MODE_VENT;
					timing_q   <= 1'b1;
					elapsed_q  <= '0;
					run_q      <= RUN_W'(REARM_VENT_MS);
					halted_q   <= 1'b0;
					pressure_q <= '0;
					percent_q  <= '0;
				end
			end
			if (cmd.load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign sts.out_free = !out_valid_q || out_ready;
	assign out_valid    = out_valid_q;
	assign out_item     = out_q;

endmodule

>>> sv/timed_valve_pressure_controller_core.sv
// channel   signals                              width  direction
// in        in_valid / in_ready / in_item        9      into block
// out       out_valid / out_ready / out_item     28     out of block
// cfg       cfg_wr_en / cfg_index / cfg_data     2+16   into block, write only
//
// A tick steps through the timer and pressure states, a percent request through
// the unit states (the divide by 100 and the vent scaling run through registered
// multiplies) and apply, a re-arm through apply alone, an unused command to done.
// Reset clears the valve state, the timer and the estimate; the registers
// return to their defaults. A held result stalls the block only when the
// following item is ready to be delivered.
module timed_valve_pressure_controller_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  tvpc_pkg::in_item_t             in_item,
	output logic                           out_valid,
	input  logic                           out_ready,
	output tvpc_pkg::out_item_t            out_item,
	input  logic                           cfg_wr_en,
	input  logic [tvpc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tvpc_pkg::CFG_DATA_W-1:0] cfg_data
);
	import tvpc_pkg::*;

	cfg_t      cfg;
	ctrl_cmd_t cmd;
	ctrl_sts_t sts;

	tvpc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	tvpc_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_command (in_item.command),
		.in_ready   (in_ready),
		.sts        (sts),
		.cmd        (cmd)
	);

	tvpc_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_item   (in_item),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

endmodule
